>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file btfn_chk.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define CHK_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication under reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/btfn_pkg.sv
// Shared types and constants for the BTFN branch target buffer.
// No dependencies.
package btfn_pkg;

  localparam int unsigned BTB_ENTRIES_DEF = 4;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned ENTRY_W         = DATA_W + 1;  // valid + target
  localparam int unsigned SIGN_BIT        = 31;
  localparam int unsigned PC_WORD_W       = DATA_W - 2;

  typedef logic [6:0] opcode_t;

  localparam opcode_t OPC_BRANCH = 7'h63;
  localparam opcode_t OPC_JAL    = 7'h6f;
  localparam opcode_t OPC_JALR   = 7'h67;

  typedef enum logic [1:0] {
    STAT_COUNTED = 2'd0,
    STAT_ZERO    = 2'd1,
    STAT_OTHER   = 2'd2
  } status_t;

endpackage

>>> rtl/core/btfn_btb_branch_predictor.sv
// Top level of the BTFN branch predictor with a direct-mapped target buffer.
// Uses btfn_pkg, btfn_idx and btfn_ram.
//
// One retired control-transfer event is taken when start is high and busy is
// low; exactly one result item comes back on the out_ ports, marked by a
// single-cycle out_strobe that the receiver cannot stall. With a power-of-two
// BUFFER_ENTRIES the buffer RAM is read at the accepting edge, the next cycle
// resolves the prediction and writes the entry back, and out_strobe is high
// in the cycle after that. busy is already low in the strobe cycle, so the
// next item can be taken at the edge that ends it.
// Other depths first compute the PC word modulo in the S_INDEX state
// (reciprocal multiply, then remainder) before the read.
// Items never overlap, so a write-back always lands before the next read.
// After reset the buffer RAM is swept to zero, one entry per cycle, and busy
// stays high during that sweep.
// Counter outputs are the statistics after this item's update and wrap at
// 2^32; they are meaningful while out_strobe is high.
module btfn_btb_branch_predictor
  import btfn_pkg::*;
#(
  parameter int unsigned BUFFER_ENTRIES = BTB_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [DATA_W-1:0] in_instruction,
  input  logic [DATA_W-1:0] in_pc,
  input  logic [DATA_W-1:0] in_actual_target,
  input  logic              in_actually_taken,
  output logic              out_strobe,
  output logic [1:0]        out_status,
  output logic              out_predicted_taken,
  output logic [DATA_W-1:0] out_btb_target,
  output logic              out_prediction_correct,
  output logic [DATA_W-1:0] out_count_total,
  output logic [DATA_W-1:0] out_count_branches,
  output logic [DATA_W-1:0] out_count_jal,
  output logic [DATA_W-1:0] out_count_jalr,
  output logic [DATA_W-1:0] out_count_taken_branches,
  output logic [DATA_W-1:0] out_count_correct_branches,
  output logic [DATA_W-1:0] out_count_correct_jal
);

  localparam int unsigned IDXW = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_INDEX,
    S_RESOLVE
  } state_t;

  state_t state_r;

  // Captured item
  logic [DATA_W-1:0] instr_r;
  logic [DATA_W-1:0] target_r;
  logic              taken_r;
  logic [IDXW-1:0]   idx_r;
  logic [IDXW-1:0]   clr_r;

  // Statistics
  logic [DATA_W-1:0] total_r, branch_r, jal_r, jalr_r;
  logic [DATA_W-1:0] taken_br_r, correct_br_r, correct_jal_r;

  // Registered result fields
  logic              strobe_r;
  status_t           status_r;
  logic              ptaken_r;
  logic [DATA_W-1:0] ptarget_r;
  logic              correct_r;

  // Index unit and RAM hookup
  logic              accept;
  logic              idx_done;
  logic [IDXW-1:0]   idx_val;
  logic              ram_we;
  logic [IDXW-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // Resolve-cycle decode
  opcode_t           opcode;
  logic              is_zero, is_br, is_jal, is_jalr, is_pred;
  logic              entry_valid;
  logic [DATA_W-1:0] entry_target;
  logic              ptaken, correct, mispredict;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && (state_r == S_IDLE);

  btfn_idx #(
    .BUFFER_ENTRIES(BUFFER_ENTRIES)
  ) u_idx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .word  (in_pc[DATA_W-1:2]),
    .done  (idx_done),
    .idx   (idx_val)
  );

  btfn_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(BUFFER_ENTRIES)
  ) u_btb (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (idx_done),
    .raddr (idx_val),
    .rdata (ram_rdata)
  );

  // Entry is {valid, target}
  assign entry_valid  = ram_rdata[ENTRY_W-1];
  assign entry_target = ram_rdata[DATA_W-1:0];

  always_comb begin
    opcode     = instr_r[6:0];
    is_zero    = (instr_r == '0);
    is_br      = !is_zero && (opcode == OPC_BRANCH);
    is_jal     = !is_zero && (opcode == OPC_JAL);
    is_jalr    = !is_zero && (opcode == OPC_JALR);
    is_pred    = is_br || is_jal;
    // Backward branch (negative offset) with a valid entry is predicted taken.
    ptaken     = is_jal || (is_br && instr_r[SIGN_BIT] && entry_valid);
    correct    = (ptaken && (entry_target == target_r)) || (!ptaken && !taken_r);
    mispredict = (state_r == S_RESOLVE) && is_pred && !correct;
  end

  // Sweep writes zeros; a misprediction loads the actual target.
  assign ram_we    = (state_r == S_CLEAR) || mispredict;
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : idx_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : {1'b1, target_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      strobe_r      <= 1'b0;
      total_r       <= '0;
      branch_r      <= '0;
      jal_r         <= '0;
      jalr_r        <= '0;
      taken_br_r    <= '0;
      correct_br_r  <= '0;
      correct_jal_r <= '0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + IDXW'(1);
          if (clr_r == IDXW'(BUFFER_ENTRIES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= idx_done ? S_RESOLVE : S_INDEX;
          end
        end
        S_INDEX: begin
          if (idx_done) begin
            state_r <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          state_r  <= S_IDLE;
          strobe_r <= 1'b1;
          if (is_pred || is_jalr) begin
            total_r <= total_r + DATA_W'(1);
          end
          if (is_jalr) begin
            jalr_r <= jalr_r + DATA_W'(1);
          end
          if (is_br) begin
            branch_r <= branch_r + DATA_W'(1);
            if (taken_r) begin
              taken_br_r <= taken_br_r + DATA_W'(1);
            end
            if (correct) begin
              correct_br_r <= correct_br_r + DATA_W'(1);
            end
          end
          if (is_jal) begin
            jal_r <= jal_r + DATA_W'(1);
            if (correct) begin
              correct_jal_r <= correct_jal_r + DATA_W'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      instr_r  <= in_instruction;
      target_r <= in_actual_target;
      taken_r  <= in_actually_taken;
    end
    if (idx_done) begin
      idx_r <= idx_val;
    end
    if (state_r == S_RESOLVE) begin
      if (is_zero) begin
        status_r <= STAT_ZERO;
      end else if (is_pred || is_jalr) begin
        status_r <= STAT_COUNTED;
      end else begin
        status_r <= STAT_OTHER;
      end
      ptaken_r  <= is_pred && ptaken;
      ptarget_r <= is_pred ? entry_target : '0;
      correct_r <= is_pred && correct;
    end
  end

  assign out_strobe                 = strobe_r;
  assign out_status                 = status_r;
  assign out_predicted_taken        = ptaken_r;
  assign out_btb_target             = ptarget_r;
  assign out_prediction_correct     = correct_r;
  assign out_count_total            = total_r;
  assign out_count_branches         = branch_r;
  assign out_count_jal              = jal_r;
  assign out_count_jalr             = jalr_r;
  assign out_count_taken_branches   = taken_br_r;
  assign out_count_correct_branches = correct_br_r;
  assign out_count_correct_jal      = correct_jal_r;

endmodule

>>> rtl/core/btfn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btfn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/btfn_idx.sv
// Buffer index unit: (pc word) modulo BUFFER_ENTRIES.
// Uses btfn_pkg. Combinational for power-of-two depths; other depths register the quotient first.
module btfn_idx
  import btfn_pkg::*;
#(
  parameter int unsigned BUFFER_ENTRIES = BTB_ENTRIES_DEF,
  localparam int unsigned IDXW = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [PC_WORD_W-1:0] word,
  output logic                 done,
  output logic [IDXW-1:0]      idx
);

  localparam bit IS_POW2 = ((BUFFER_ENTRIES & (BUFFER_ENTRIES - 1)) == 0);

  generate
    if (BUFFER_ENTRIES == 1) begin : g_single
      assign done = start;
      assign idx  = '0;
    end else if (IS_POW2) begin : g_pow2
      assign done = start;
      assign idx  = word[IDXW-1:0];
    end else begin : g_recip
      // Quotient by reciprocal multiply, exact for every PC_WORD_W-bit word:
      // q = (word * ceil(2^SH / N)) >> SH. Quotient is registered at start,
      // the remainder word - q * N is ready (done) the cycle after.
      localparam int unsigned SH  = PC_WORD_W + IDXW;
      localparam int unsigned MW  = PC_WORD_W + 1;
      localparam int unsigned PW  = PC_WORD_W + MW;
      localparam logic [63:0] M64 =
        ((64'd1 << SH) + 64'(BUFFER_ENTRIES) - 64'd1) / 64'(BUFFER_ENTRIES);
      localparam logic [MW-1:0] MUL = MW'(M64);
      localparam logic [PC_WORD_W-1:0] NVAL = PC_WORD_W'(BUFFER_ENTRIES);

      logic                 busy_r;
      logic [PC_WORD_W-1:0] word_r;
      logic [PC_WORD_W-1:0] quot_r;
      logic [PW-1:0]        prod;
      logic [PC_WORD_W-1:0] rem;

      assign prod = PW'(word) * PW'(MUL);
      assign rem  = word_r - quot_r * NVAL;
      assign done = busy_r;
      assign idx  = rem[IDXW-1:0];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
        end else begin
          busy_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          word_r <= word;
          quot_r <= PC_WORD_W'(prod >> SH);
        end
      end
    end
  endgenerate

endmodule

>>> rtl/core/btfn_chk.sv
// Port-level checker for btfn_btb_branch_predictor, bound to the top level.
// Uses btfn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module btfn_chk
  import btfn_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input logic [1:0]        out_status,
  input logic              out_predicted_taken,
  input logic [DATA_W-1:0] out_btb_target,
  input logic              out_prediction_correct,
  input logic [DATA_W-1:0] out_count_total
);

  logic ignored;
  logic no_guess;
  assign ignored  = out_strobe && (out_status != STAT_COUNTED);
  assign no_guess = !out_predicted_taken && !out_prediction_correct &&
                    (out_btb_target == '0);

  // An accepted item sets busy at the accepting edge.
  `CHK_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

  // Results are never back to back.
  `CHK_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe)

  // A result only follows work in progress.
  `CHK_IMPLIES(a_strobe_after_busy, clk, rst_n, out_strobe, $past(busy))

  // Ignored items carry no prediction.
  `CHK_IMPLIES(a_ignored_clean, clk, rst_n, ignored, no_guess)

  // Ignored items leave the total unchanged.
  `CHK_IMPLIES(a_ignored_total, clk, rst_n, ignored, out_count_total == $past(out_count_total))

endmodule

bind btfn_btb_branch_predictor btfn_chk u_chk (.*);
